[rtl/csv_tok_pkg.sv]
package csv_tok_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] kind_type;

   localparam kind_type TK_DATA   = 2'd0;
   localparam kind_type TK_FIELD  = 2'd1;
   localparam kind_type TK_RECORD = 2'd2;

   localparam byte_type CH_QUOTE = 8'h22;
   localparam byte_type CH_COMMA = 8'h2C;
   localparam byte_type CH_CR    = 8'h0D;
   localparam byte_type CH_LF    = 8'h0A;
   localparam byte_type BOM_0    = 8'hEF;
   localparam byte_type BOM_1    = 8'hBB;
   localparam byte_type BOM_2    = 8'hBF;

   localparam int MAX_TOKENS = 4;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      PH_START,
      PH_UNQUOTED,
      PH_QUOTED,
      PH_QUOTE_SEEN
   } phase_type;

   typedef struct packed {
      kind_type kind;
      byte_type value;
   } token_type;

   typedef struct packed {
      token_type [MAX_TOKENS-1:0] tok;
      logic [2:0]                 cnt;
   } group_type;

   typedef struct packed {
      logic [1:0]  bom_count;
      logic        mark_done;
      logic        parity;
      phase_type   phase;
      logic        cr_pending;
      logic        has_content;
      group_type   grp;
   } ctx_type;

endpackage

[rtl/csv_tok_req_if.sv]
interface csv_tok_req_if;
   logic                 valid;
   logic                 ready;
   csv_tok_pkg::byte_type data_byte;
   logic                 first_of_file;

   modport source (output valid, output data_byte, output first_of_file, input ready);
   modport sink (input valid, input data_byte, input first_of_file, output ready);
endinterface

[rtl/csv_tok_rsp_if.sv]
interface csv_tok_rsp_if;
   logic                 valid;
   logic                 ready;
   csv_tok_pkg::kind_type token_kind;
   csv_tok_pkg::byte_type byte_value;

   modport source (output valid, output token_kind, output byte_value, input ready);
   modport sink (input valid, input token_kind, input byte_value, output ready);
endinterface

[rtl/csv_record_tokenizer.sv]
// a token is offered on rsp once its byte's group is registered and at the queue head
// throughput: one byte per cycle while each byte yields at most one token and rsp is ready
// a byte that yields n tokens (n up to 4) holds the single output port until all n are taken
// tokens of one byte travel as a group through a two-entry group queue
// reset (synchronous): parser state and queue cleared, byte-order-mark check armed
module csv_record_tokenizer (
   input logic            clock,
   input logic            reset,
   csv_tok_req_if.sink    req_bus,
   csv_tok_rsp_if.source  rsp_bus
);

   function automatic csv_tok_pkg::ctx_type put_tok(csv_tok_pkg::ctx_type s,
                                                    csv_tok_pkg::kind_type k,
                                                    csv_tok_pkg::byte_type v);
      csv_tok_pkg::ctx_type r;
      r = s;
      if (r.grp.cnt < 3'(csv_tok_pkg::MAX_TOKENS)) begin
         r.grp.tok[r.grp.cnt[1:0]].kind = k;
         r.grp.tok[r.grp.cnt[1:0]].value = v;
         r.grp.cnt = r.grp.cnt + 3'd1;
      end
      return r;
   endfunction

   function automatic csv_tok_pkg::ctx_type line_byte(csv_tok_pkg::ctx_type s,
                                                      csv_tok_pkg::byte_type c);
      csv_tok_pkg::ctx_type r;
      r = s;
      r.has_content = 1'b1;
      case (r.phase)
         csv_tok_pkg::PH_START: begin
            if (c == csv_tok_pkg::CH_QUOTE) begin
               r.phase = csv_tok_pkg::PH_QUOTED;
            end else if (c == csv_tok_pkg::CH_COMMA) begin
               r = put_tok(r, csv_tok_pkg::TK_FIELD, 8'd0);
            end else begin
               r = put_tok(r, csv_tok_pkg::TK_DATA, c);
               r.phase = csv_tok_pkg::PH_UNQUOTED;
            end
         end
         csv_tok_pkg::PH_UNQUOTED: begin
            if (c == csv_tok_pkg::CH_COMMA) begin
               r = put_tok(r, csv_tok_pkg::TK_FIELD, 8'd0);
               r.phase = csv_tok_pkg::PH_START;
            end else begin
               r = put_tok(r, csv_tok_pkg::TK_DATA, c);
            end
         end
         csv_tok_pkg::PH_QUOTED: begin
            if (c == csv_tok_pkg::CH_QUOTE) begin
               r.phase = csv_tok_pkg::PH_QUOTE_SEEN;
            end else begin
               r = put_tok(r, csv_tok_pkg::TK_DATA, c);
            end
         end
         default: begin
            if (c == csv_tok_pkg::CH_QUOTE) begin
               r = put_tok(r, csv_tok_pkg::TK_DATA, csv_tok_pkg::CH_QUOTE);
               r.phase = csv_tok_pkg::PH_QUOTED;
            end else begin
               r = put_tok(r, csv_tok_pkg::TK_FIELD, 8'd0);
               if (c == csv_tok_pkg::CH_COMMA) begin
                  r.phase = csv_tok_pkg::PH_START;
               end else begin
                  r = put_tok(r, csv_tok_pkg::TK_DATA, c);
                  r.phase = csv_tok_pkg::PH_UNQUOTED;
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic csv_tok_pkg::ctx_type raw_byte(csv_tok_pkg::ctx_type s,
                                                     csv_tok_pkg::byte_type b);
      csv_tok_pkg::ctx_type r;
      r = s;
      if (b == csv_tok_pkg::CH_QUOTE) begin
         r.parity = ~r.parity;
      end
      if (b == csv_tok_pkg::CH_LF && !r.parity) begin
         r.cr_pending = 1'b0;
         if (r.has_content) begin
            if (r.phase != csv_tok_pkg::PH_START) begin
               r = put_tok(r, csv_tok_pkg::TK_FIELD, 8'd0);
            end
            r = put_tok(r, csv_tok_pkg::TK_RECORD, 8'd0);
         end
         r.phase = csv_tok_pkg::PH_START;
         r.has_content = 1'b0;
      end else begin
         if (r.cr_pending) begin
            r.cr_pending = 1'b0;
            r = line_byte(r, csv_tok_pkg::CH_CR);
         end
         if (b == csv_tok_pkg::CH_CR) begin
            r.cr_pending = 1'b1;
         end else begin
            r = line_byte(r, b);
         end
      end
      return r;
   endfunction

   logic [1:0]              bom_count_ff;
   logic                    mark_done_ff;
   logic                    parity_ff;
   csv_tok_pkg::phase_type  phase_ff;
   logic                    cr_pending_ff;
   logic                    has_content_ff;

   csv_tok_pkg::group_type  grp_ff [csv_tok_pkg::QUEUE_DEPTH];
   logic                    wr_ptr_ff;
   logic                    rd_ptr_ff;
   logic [1:0]              fill_ff;
   logic [1:0]              sub_ff;

   logic [1:0]              fill_in;
   logic [1:0]              sub_in;
   logic                    rd_ptr_in;
   logic                    wr_ptr_in;

   csv_tok_pkg::ctx_type    ctx;
   logic                    skip;
   logic                    req_accept;
   logic                    push;
   logic                    pop;
   logic                    last;
   csv_tok_pkg::group_type  head;
   csv_tok_pkg::token_type  head_tok;

   assign req_accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = fill_ff != 2'(csv_tok_pkg::QUEUE_DEPTH);

   always_comb begin
      ctx.bom_count = bom_count_ff;
      ctx.mark_done = mark_done_ff;
      ctx.parity = parity_ff;
      ctx.phase = phase_ff;
      ctx.cr_pending = cr_pending_ff;
      ctx.has_content = has_content_ff;
      ctx.grp = '0;
      skip = 1'b0;
      if (req_bus.first_of_file) begin
         ctx.bom_count = 2'd0;
         ctx.mark_done = 1'b0;
         ctx.parity = 1'b0;
         ctx.phase = csv_tok_pkg::PH_START;
         ctx.cr_pending = 1'b0;
         ctx.has_content = 1'b0;
      end
      if (!ctx.mark_done) begin
         case (ctx.bom_count)
            2'd0: begin
               if (req_bus.data_byte == csv_tok_pkg::BOM_0) begin
                  ctx.bom_count = 2'd1;
                  skip = 1'b1;
               end
            end
            2'd1: begin
               if (req_bus.data_byte == csv_tok_pkg::BOM_1) begin
                  ctx.bom_count = 2'd2;
                  skip = 1'b1;
               end else begin
                  ctx = raw_byte(ctx, csv_tok_pkg::BOM_0);
               end
            end
            2'd2: begin
               if (req_bus.data_byte == csv_tok_pkg::BOM_2) begin
                  ctx.mark_done = 1'b1;
                  ctx.bom_count = 2'd0;
                  skip = 1'b1;
               end else begin
                  ctx = raw_byte(ctx, csv_tok_pkg::BOM_0);
                  ctx = raw_byte(ctx, csv_tok_pkg::BOM_1);
               end
            end
            default: begin
            end
         endcase
         if (!skip) begin
            ctx.mark_done = 1'b1;
            ctx.bom_count = 2'd0;
         end
      end
      if (!skip) begin
         ctx = raw_byte(ctx, req_bus.data_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bom_count_ff <= 2'd0;
         mark_done_ff <= 1'b0;
         parity_ff <= 1'b0;
         phase_ff <= csv_tok_pkg::PH_START;
         cr_pending_ff <= 1'b0;
         has_content_ff <= 1'b0;
      end else if (req_accept) begin
         bom_count_ff <= ctx.bom_count;
         mark_done_ff <= ctx.mark_done;
         parity_ff <= ctx.parity;
         phase_ff <= ctx.phase;
         cr_pending_ff <= ctx.cr_pending;
         has_content_ff <= ctx.has_content;
      end
   end

   // group queue: one entry per byte that yields tokens
   assign head = grp_ff[rd_ptr_ff];
   assign head_tok = head.tok[sub_ff];
   assign rsp_bus.valid = fill_ff != 2'd0;
   assign rsp_bus.token_kind = head_tok.kind;
   assign rsp_bus.byte_value = head_tok.value;

   assign push = req_accept && (ctx.grp.cnt != 3'd0);
   assign pop = rsp_bus.valid && rsp_bus.ready;
   assign last = {1'b0, sub_ff} == (head.cnt - 3'd1);

   always_comb begin
      fill_in = fill_ff;
      sub_in = sub_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         if (last) begin
            sub_in = 2'd0;
            rd_ptr_in = ~rd_ptr_ff;
         end else begin
            sub_in = sub_ff + 2'd1;
         end
      end
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop && last};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
         sub_ff <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         sub_ff <= sub_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         grp_ff[wr_ptr_ff] <= ctx.grp;
      end
   end

   a_more_in_group: assert property (@(posedge clock) disable iff (reset)
      (pop && !last) |=> rsp_bus.valid)
      else $error("group drained early");

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (head.cnt != 3'd0 && head.cnt <= 3'(csv_tok_pkg::MAX_TOKENS)))
      else $error("head group count out of range");

   a_empty_sub: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd0) |-> (sub_ff == 2'd0 && rd_ptr_ff == wr_ptr_ff))
      else $error("empty queue with stale pointers");

   a_fill_hold: assert property (@(posedge clock) disable iff (reset)
      (!push && !pop) |=> $stable(fill_ff))
      else $error("fill changed without traffic");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 290;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int REPORT_LIMIT   = 10;
   localparam string TEXT_CHARS  = "abcdefxyzABCXYZ0123456789 .;-_";

   class token_scoreboard;
      logic [1:0]             bom_count;
      logic                   mark_done;
      logic                   parity;
      csv_tok_pkg::phase_type phase;
      logic                   cr_held;
      logic                   has_content;
      int                     step_tokens;
      int                     mismatches;
      csv_tok_pkg::token_type expected_tokens[$];

      function new();
         clear_parser();
         mismatches = 0;
      endfunction

      function void clear_parser();
         bom_count   = 2'd0;
         mark_done   = 1'b0;
         parity      = 1'b0;
         phase       = csv_tok_pkg::PH_START;
         cr_held     = 1'b0;
         has_content = 1'b0;
      endfunction

      function void push_token(csv_tok_pkg::kind_type kind, csv_tok_pkg::byte_type value);
         csv_tok_pkg::token_type t;
         if (step_tokens >= csv_tok_pkg::MAX_TOKENS) return;
         t.kind  = kind;
         t.value = value;
         expected_tokens.insert(expected_tokens.size(), t);
         step_tokens++;
      endfunction

      function void field_byte(csv_tok_pkg::byte_type c);
         has_content = 1'b1;
         case (phase)
            csv_tok_pkg::PH_START: begin
               if (c == csv_tok_pkg::CH_QUOTE) phase = csv_tok_pkg::PH_QUOTED;
               else if (c == csv_tok_pkg::CH_COMMA) push_token(csv_tok_pkg::TK_FIELD, 8'h00);
               else begin
                  push_token(csv_tok_pkg::TK_DATA, c);
                  phase = csv_tok_pkg::PH_UNQUOTED;
               end
            end
            csv_tok_pkg::PH_UNQUOTED: begin
               if (c == csv_tok_pkg::CH_COMMA) begin
                  push_token(csv_tok_pkg::TK_FIELD, 8'h00);
                  phase = csv_tok_pkg::PH_START;
               end else begin
                  push_token(csv_tok_pkg::TK_DATA, c);
               end
            end
            csv_tok_pkg::PH_QUOTED: begin
               if (c == csv_tok_pkg::CH_QUOTE) phase = csv_tok_pkg::PH_QUOTE_SEEN;
               else push_token(csv_tok_pkg::TK_DATA, c);
            end
            default: begin
               if (c == csv_tok_pkg::CH_QUOTE) begin
                  push_token(csv_tok_pkg::TK_DATA, csv_tok_pkg::CH_QUOTE);
                  phase = csv_tok_pkg::PH_QUOTED;
               end else begin
                  push_token(csv_tok_pkg::TK_FIELD, 8'h00);
                  if (c == csv_tok_pkg::CH_COMMA) phase = csv_tok_pkg::PH_START;
                  else begin
                     push_token(csv_tok_pkg::TK_DATA, c);
                     phase = csv_tok_pkg::PH_UNQUOTED;
                  end
               end
            end
         endcase
      endfunction

      function void close_line();
         cr_held = 1'b0;
         if (has_content) begin
            if (phase != csv_tok_pkg::PH_START) push_token(csv_tok_pkg::TK_FIELD, 8'h00);
            push_token(csv_tok_pkg::TK_RECORD, 8'h00);
         end
         phase       = csv_tok_pkg::PH_START;
         has_content = 1'b0;
      endfunction

      function void line_char(csv_tok_pkg::byte_type b);
         if (b == csv_tok_pkg::CH_QUOTE) parity = ~parity;
         if (b == csv_tok_pkg::CH_LF && parity == 1'b0) begin
            close_line();
            return;
         end
         if (cr_held) begin
            cr_held = 1'b0;
            field_byte(csv_tok_pkg::CH_CR);
         end
         if (b == csv_tok_pkg::CH_CR) begin
            cr_held = 1'b1;
            return;
         end
         field_byte(b);
      endfunction

      function void note_byte(csv_tok_pkg::byte_type b, logic first);
         step_tokens = 0;
         if (first) clear_parser();
         if (!mark_done) begin
            if (bom_count == 2'd0) begin
               if (b == csv_tok_pkg::BOM_0) begin
                  bom_count = 2'd1;
                  return;
               end
            end else if (bom_count == 2'd1) begin
               if (b == csv_tok_pkg::BOM_1) begin
                  bom_count = 2'd2;
                  return;
               end
               line_char(csv_tok_pkg::BOM_0);
            end else if (bom_count == 2'd2) begin
               if (b == csv_tok_pkg::BOM_2) begin
                  mark_done = 1'b1;
                  bom_count = 2'd0;
                  return;
               end
               line_char(csv_tok_pkg::BOM_0);
               line_char(csv_tok_pkg::BOM_1);
            end
            mark_done = 1'b1;
            bom_count = 2'd0;
         end
         line_char(b);
      endfunction

      function void note_mismatch(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
      endfunction

      function void check_token(csv_tok_pkg::kind_type kind, csv_tok_pkg::byte_type value);
         csv_tok_pkg::token_type want;
         if (expected_tokens.size() == 0) begin
            note_mismatch($sformatf("unexpected token kind %0d value %02h", kind, value));
            return;
         end
         want = expected_tokens.pop_front();
         if (kind !== want.kind)
            note_mismatch($sformatf("token_kind expected %0d actual %0d", want.kind, kind));
         if (value !== want.value)
            note_mismatch($sformatf("byte_value expected %02h actual %02h", want.value, value));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   csv_tok_req_if req_bus ();
   csv_tok_rsp_if rsp_bus ();

   csv_record_tokenizer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   token_scoreboard       scoreboard;
   csv_tok_pkg::byte_type file_text[$];
   logic [8:0]            directed_beats[$];
   int                    burst_left = 0;
   int                    hold_off_requests = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            scoreboard.note_byte(req_bus.data_byte, req_bus.first_of_file);
         if (rsp_bus.valid && rsp_bus.ready)
            scoreboard.check_token(rsp_bus.token_kind, rsp_bus.byte_value);
      end
   end

   function automatic void add_text(csv_tok_pkg::byte_type b);
      file_text.insert(file_text.size(), b);
   endfunction

   function automatic csv_tok_pkg::byte_type plain_char();
      if ($urandom_range(0, 7) == 0) return csv_tok_pkg::byte_type'($urandom_range(0, 255));
      return csv_tok_pkg::byte_type'(TEXT_CHARS[$urandom_range(0, TEXT_CHARS.len() - 1)]);
   endfunction

   function automatic void add_field();
      int                    len;
      csv_tok_pkg::byte_type c;
      case ($urandom_range(0, 19))
         0, 1, 2: ;
         3, 4: begin
            len = $urandom_range(1, 3);
            repeat (len) add_text(csv_tok_pkg::byte_type'($urandom_range(0, 255)));
         end
         5, 6, 7, 8, 9, 10, 11: begin
            add_text(csv_tok_pkg::CH_QUOTE);
            len = $urandom_range(0, 5);
            repeat (len) begin
               case ($urandom_range(0, 5))
                  0: c = csv_tok_pkg::CH_COMMA;
                  1: c = csv_tok_pkg::CH_CR;
                  2: c = csv_tok_pkg::CH_LF;
                  3: c = csv_tok_pkg::CH_QUOTE;
                  default: c = plain_char();
               endcase
               if (c == csv_tok_pkg::CH_QUOTE) add_text(csv_tok_pkg::CH_QUOTE);
               add_text(c);
            end
            add_text(csv_tok_pkg::CH_QUOTE);
            // stray byte after the closing quote
            if ($urandom_range(0, 7) == 0) add_text(plain_char());
         end
         default: begin
            len = $urandom_range(1, 5);
            repeat (len) add_text(plain_char());
         end
      endcase
   endfunction

   task automatic send_byte(input csv_tok_pkg::byte_type b, input logic first);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= b;
      req_bus.first_of_file <= first;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   initial begin : rsp_stall_pattern
      int seg_len;
      int mode;
      int step;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_requests > 0) begin
            hold_off_requests--;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            seg_len = $urandom_range(8, 60);
            mode    = $urandom_range(0, 3);
            for (step = 0; step < seg_len; step++) begin
               case (mode)
                  0: rsp_bus.ready <= 1'b1;
                  1: rsp_bus.ready <= 1'($urandom_range(0, 1));
                  2: rsp_bus.ready <= (step % 3 == 0);
                  default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int   idx;
      int   nrec;
      int   nfld;
      int   pick;
      int   random_sent;
      logic mid_hold_done;
      scoreboard    = new();
      random_sent   = 0;
      mid_hold_done = 1'b0;
      req_bus.valid         <= 1'b0;
      req_bus.data_byte     <= 8'h00;
      req_bus.first_of_file <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // partial mark after reset, extremes, doubled quote, cr inside quotes,
      // dropped cr and empty line, full mark, record end in an open quoted field,
      // held cr as data, new file mid-line, four tokens from one beat
      directed_beats = '{
         {1'b0, csv_tok_pkg::BOM_0},    {1'b0, csv_tok_pkg::BOM_1},
         {1'b0, 8'h00},                 {1'b0, 8'hFF},
         {1'b0, csv_tok_pkg::CH_COMMA}, {1'b0, csv_tok_pkg::CH_QUOTE},
         {1'b0, csv_tok_pkg::CH_QUOTE}, {1'b0, csv_tok_pkg::CH_QUOTE},
         {1'b0, csv_tok_pkg::CH_CR},    {1'b0, csv_tok_pkg::CH_LF},
         {1'b0, csv_tok_pkg::CH_QUOTE}, {1'b0, 8'h78},
         {1'b0, csv_tok_pkg::CH_COMMA}, {1'b0, csv_tok_pkg::CH_CR},
         {1'b0, csv_tok_pkg::CH_LF},    {1'b0, csv_tok_pkg::CH_LF},
         {1'b1, csv_tok_pkg::BOM_0},    {1'b0, csv_tok_pkg::BOM_1},
         {1'b0, csv_tok_pkg::BOM_2},    {1'b0, 8'h61},
         {1'b0, csv_tok_pkg::CH_QUOTE}, {1'b0, csv_tok_pkg::CH_COMMA},
         {1'b0, csv_tok_pkg::CH_QUOTE}, {1'b0, csv_tok_pkg::CH_LF},
         {1'b0, csv_tok_pkg::CH_CR},    {1'b0, 8'h78},
         {1'b0, csv_tok_pkg::CH_CR},    {1'b1, 8'h62},
         {1'b1, csv_tok_pkg::BOM_0},    {1'b0, csv_tok_pkg::BOM_1},
         {1'b0, csv_tok_pkg::CH_LF}
      };
      for (idx = 0; idx < directed_beats.size(); idx++)
         send_byte(directed_beats[idx][7:0], directed_beats[idx][8]);

      hold_off_requests = 1;
      while (random_sent < RANDOM_ITEMS) begin
         file_text.delete();
         pick = $urandom_range(0, 9);
         if (pick <= 2) file_text = '{csv_tok_pkg::BOM_0, csv_tok_pkg::BOM_1, csv_tok_pkg::BOM_2};
         else if (pick == 3) add_text(csv_tok_pkg::BOM_0);
         else if (pick == 4) file_text = '{csv_tok_pkg::BOM_0, csv_tok_pkg::BOM_1};
         nrec = $urandom_range(1, 4);
         repeat (nrec) begin
            nfld = $urandom_range(1, 4);
            for (idx = 0; idx < nfld; idx++) begin
               if (idx != 0) add_text(csv_tok_pkg::CH_COMMA);
               add_field();
            end
            if ($urandom_range(0, 5) == 0) add_text(csv_tok_pkg::CH_COMMA);
            pick = $urandom_range(0, 9);
            if (pick >= 5) add_text(csv_tok_pkg::CH_CR);
            add_text(csv_tok_pkg::CH_LF);
            if (pick == 9) begin
               add_text(csv_tok_pkg::CH_CR);
               add_text(csv_tok_pkg::CH_LF);
            end
            if (pick == 0) add_text(csv_tok_pkg::CH_LF);
         end
         // unterminated last line
         if ($urandom_range(0, 5) == 0) add_field();
         for (idx = 0; idx < file_text.size(); idx++) begin
            send_byte(file_text[idx], idx == 0);
            random_sent++;
         end
         if (!mid_hold_done && random_sent > RANDOM_ITEMS / 2) begin
            hold_off_requests++;
            mid_hold_done = 1'b1;
         end
      end
      req_bus.valid <= 1'b0;
      @(posedge clock);

      while (scoreboard.expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.expected_tokens.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

[files.f]
rtl/csv_tok_pkg.sv
rtl/csv_tok_req_if.sv
rtl/csv_tok_rsp_if.sv
rtl/csv_record_tokenizer.sv
dv/testbench.sv
